// ----- design/gpio_pkg.sv -----
// shared types and constants for the gpio port register block
// register offsets, opcodes and default sizing; no dependencies
package gpio_pkg;

	localparam int unsigned REGION_BYTES_DEF = 1024;
	localparam int unsigned OFS_W            = 12;
	localparam int unsigned DATA_W           = 32;
	localparam int unsigned PINS             = 16;
	localparam int unsigned LOCK_W           = PINS + 1;
	localparam int unsigned CFG_IDX_W        = 2;

	typedef logic [OFS_W-1:0]  ofs_t;
	typedef logic [DATA_W-1:0] word_t;
	typedef logic [PINS-1:0]   pins_t;

	// opcodes of an input beat
	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_RESET = 2'd2,
		OP_NONE  = 2'd3
	} opcode_t;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MODE_RST  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SPEED_RST = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PULL_RST  = 2'd2;

	// register map
	localparam ofs_t OFS_MODE  = 12'h000;
	localparam ofs_t OFS_TYPE  = 12'h004;
	localparam ofs_t OFS_SPEED = 12'h008;
	localparam ofs_t OFS_PULL  = 12'h00C;
	localparam ofs_t OFS_IDR   = 12'h010;
	localparam ofs_t OFS_ODR   = 12'h014;
	localparam ofs_t OFS_BSRR  = 12'h018;
	localparam ofs_t OFS_LOCK  = 12'h01C;
	localparam ofs_t OFS_ALTL  = 12'h020;
	localparam ofs_t OFS_ALTH  = 12'h024;

	// one result beat
	typedef struct packed {
		word_t read_data;
		logic  access_error;
	} result_t;

endpackage

// ----- design/gpio_port_registers_with_lock.sv -----
// register block of a 16-pin gpio port with configuration lock
// depends on gpio_pkg for the register map, opcodes and result type
//
// Each input beat is one register read, one register write, a port reset or
// an unused opcode, and produces exactly one result beat (read data and an
// error flag). The whole access is decoded and the port state updated at the
// edge that accepts it, and the result is registered at that same edge. A
// two-entry output buffer (result register plus skid register) holds results,
// so a new beat is accepted while a finished result waits, and in_stall comes
// straight from a flop; it only rises after the consumer has held off two
// results. The block takes one beat per cycle while in_stall is low. The
// reset value registers for mode, speed and pull are written over the cfg
// port (always ready) and only take effect at the next port reset beat. The
// lock sequence is write key 1, write key 0, write key 1 with the same low
// half, then a read of the lock register; once locked the control registers
// ignore writes until a port reset. Reads and writes at offsets at or beyond
// REGION_BYTES give an error with no state change.
module gpio_port_registers_with_lock #(
	parameter int unsigned REGION_BYTES = gpio_pkg::REGION_BYTES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// item input channel
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     opcode,
	input  logic [gpio_pkg::OFS_W-1:0]     byte_offset,
	input  logic [gpio_pkg::DATA_W-1:0]    write_data,
	input  logic [gpio_pkg::PINS-1:0]      pin_levels,
	// result output channel
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [gpio_pkg::DATA_W-1:0]    read_data,
	output logic                           access_error,
	// configuration write channel
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [gpio_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gpio_pkg::DATA_W-1:0]    cfg_data
);
	import gpio_pkg::*;

	// lock sequence phases
	typedef enum logic [2:0] {
		LK_FIRST,
		LK_SECOND,
		LK_THIRD,
		LK_READ,
		LK_LOCKED
	} lock_phase_t;

	localparam logic [OFS_W:0] REGION_LIMIT = (OFS_W+1)'(REGION_BYTES);

	// reset value registers
	word_t mode_rst_q, speed_rst_q, pull_rst_q;

	// port state
	word_t       mode_q, speed_q, pull_q, altl_q, alth_q;
	pins_t       otype_q, odr_q;
	logic [LOCK_W-1:0] lock_word_q;
	lock_phase_t lock_phase_q;

	// output buffer
	logic    out_valid_q, skid_valid_q;
	result_t out_q, skid_q;

	// next-state values
	word_t       mode_d, speed_d, pull_d, altl_d, alth_d;
	pins_t       otype_d, odr_d;
	logic [LOCK_W-1:0] lock_word_d;
	lock_phase_t lock_phase_d;
	result_t     res;

	logic accept, drain, in_range, locked, is_read, is_write;

	assign cfg_ready = 1'b1;
	assign in_stall  = skid_valid_q;
	assign accept    = in_valid && !skid_valid_q;
	assign drain     = out_valid_q && !out_stall;

	assign out_valid    = out_valid_q;
	assign read_data    = out_q.read_data;
	assign access_error = out_q.access_error;

	assign in_range = {1'b0, byte_offset} < REGION_LIMIT;
	assign locked   = (lock_phase_q == LK_LOCKED);
	assign is_read  = (opcode == OP_READ) && in_range;
	assign is_write = (opcode == OP_WRITE) && in_range;

	// access decode and state update for the beat on the input ports
	always_comb begin
		mode_d       = mode_q;
		speed_d      = speed_q;
		pull_d       = pull_q;
		altl_d       = altl_q;
		alth_d       = alth_q;
		otype_d      = otype_q;
		odr_d        = odr_q;
		lock_word_d  = lock_word_q;
		lock_phase_d = lock_phase_q;
		res          = '0;

		if (opcode == OP_RESET) begin
			mode_d       = mode_rst_q;
			speed_d      = speed_rst_q;
			pull_d       = pull_rst_q;
			altl_d       = '0;
			alth_d       = '0;
			otype_d      = '0;
			odr_d        = '0;
			lock_word_d  = '0;
			lock_phase_d = LK_FIRST;
		end else if ((opcode == OP_READ || opcode == OP_WRITE) && !in_range) begin
			res.access_error = 1'b1;
		end else if (is_read) begin
			case (byte_offset)
				OFS_MODE:  res.read_data = mode_q;
				OFS_TYPE:  res.read_data = {{(DATA_W-PINS){1'b0}}, otype_q};
				OFS_SPEED: res.read_data = speed_q;
				OFS_PULL:  res.read_data = pull_q;
				OFS_IDR:   res.read_data = {{(DATA_W-PINS){1'b0}}, pin_levels};
				OFS_ODR:   res.read_data = {{(DATA_W-PINS){1'b0}}, odr_q};
				OFS_BSRR:  res.access_error = 1'b1;
				OFS_LOCK: begin
					// a read ends the key sequence: locks from the last step, aborts earlier
					res.read_data = {{(DATA_W-LOCK_W){1'b0}}, lock_word_q};
					case (lock_phase_q)
						LK_SECOND, LK_THIRD: lock_phase_d = LK_FIRST;
						LK_READ:             lock_phase_d = LK_LOCKED;
						default:             lock_phase_d = lock_phase_q;
					endcase
				end
				OFS_ALTL:  res.read_data = altl_q;
				OFS_ALTH:  res.read_data = alth_q;
				default:   res.read_data = '0;
			endcase
		end else if (is_write) begin
			case (byte_offset)
				OFS_MODE:  if (!locked) mode_d = write_data;
				OFS_TYPE:  if (!locked) otype_d = write_data[PINS-1:0];
				OFS_SPEED: if (!locked) speed_d = write_data;
				OFS_PULL:  if (!locked) pull_d = write_data;
				OFS_IDR:   res.access_error = 1'b1;
				OFS_ODR:   odr_d = write_data[PINS-1:0];
				// set wins over reset for a pin named in both halves
				OFS_BSRR:  odr_d = (odr_q & ~write_data[PINS-1:0]) | write_data[DATA_W-1:PINS];
				OFS_LOCK: begin
					if (!locked) begin
						if ((lock_phase_q == LK_SECOND || lock_phase_q == LK_THIRD) &&
							lock_word_q[PINS-1:0] != write_data[PINS-1:0]) begin
							// low half changed mid-sequence
							lock_phase_d = LK_FIRST;
						end else begin
							case (lock_phase_q)
								LK_FIRST: begin
									if (write_data[PINS]) begin
										lock_word_d  = write_data[LOCK_W-1:0];
										lock_phase_d = LK_SECOND;
									end
								end
								LK_SECOND: begin
									if (!write_data[PINS]) begin
										lock_word_d  = write_data[LOCK_W-1:0];
										lock_phase_d = LK_THIRD;
									end else begin
										lock_phase_d = LK_FIRST;
									end
								end
								LK_THIRD: begin
									if (write_data[PINS]) begin
										lock_word_d  = write_data[LOCK_W-1:0];
										lock_phase_d = LK_READ;
									end else begin
										lock_phase_d = LK_FIRST;
									end
								end
								default: lock_phase_d = LK_FIRST;
							endcase
						end
					end
				end
				OFS_ALTL:  if (!locked) altl_d = write_data;
				OFS_ALTH:  if (!locked) alth_d = write_data;
				default:   res = '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_rst_q   <= '0;
			speed_rst_q  <= '0;
			pull_rst_q   <= '0;
			mode_q       <= '0;
			speed_q      <= '0;
			pull_q       <= '0;
			altl_q       <= '0;
			alth_q       <= '0;
			otype_q      <= '0;
			odr_q        <= '0;
			lock_word_q  <= '0;
			lock_phase_q <= LK_FIRST;
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
			out_q        <= '0;
			skid_q       <= '0;
		end else begin
			// reset value registers, index beyond the list is dropped
			if (cfg_valid) begin
				case (cfg_index)
					CFG_MODE_RST:  mode_rst_q  <= cfg_data;
					CFG_SPEED_RST: speed_rst_q <= cfg_data;
					CFG_PULL_RST:  pull_rst_q  <= cfg_data;
					default:       mode_rst_q  <= mode_rst_q;
				endcase
			end

			if (accept) begin
				mode_q       <= mode_d;
				speed_q      <= speed_d;
				pull_q       <= pull_d;
				altl_q       <= altl_d;
				alth_q       <= alth_d;
				otype_q      <= otype_d;
				odr_q        <= odr_d;
				lock_word_q  <= lock_word_d;
				lock_phase_q <= lock_phase_d;
			end

			// two-entry output buffer
			if (drain || !out_valid_q) begin
				if (skid_valid_q) begin
					out_q        <= skid_q;
					out_valid_q  <= 1'b1;
					skid_valid_q <= 1'b0;
				end else if (accept) begin
					out_q       <= res;
					out_valid_q <= 1'b1;
				end else begin
					out_valid_q <= 1'b0;
				end
			end else if (accept) begin
				skid_q       <= res;
				skid_valid_q <= 1'b1;
			end
		end
	end

endmodule

// ----- tb/sv/tb_gpio_port_registers_with_lock.sv -----
// self-checking testbench for the gpio port register block with lock
// depends on gpio_pkg and gpio_port_registers_with_lock; needs no other file
// directed table first, then randomized accesses and lock sequences under several reset values
module tb_gpio_port_registers_with_lock;
	timeunit 1ns;
	timeprecision 1ps;

	import gpio_pkg::*;

	localparam int unsigned REGION         = REGION_BYTES_DEF;
	localparam int          N_DIR          = 25;
	localparam int          BEATS_PER_PHASE = 130;
	localparam int          N_PHASES       = 5;
	localparam int          STALL_LIMIT    = 2000;
	localparam int          MAX_REPORTS    = 100;

	// offsets around the edge of the port region
	localparam ofs_t OFS_TOP         = 12'hFFF;
	localparam ofs_t OFS_REGION_END  = ofs_t'(REGION);
	localparam ofs_t OFS_LAST_WORD   = ofs_t'(REGION - 4);
	localparam ofs_t OFS_UNALIGNED   = 12'h002;

	// config index with no register behind it
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	// progress of the lock key sequence
	typedef enum logic [2:0] {
		LK_FIRST,
		LK_SECOND,
		LK_THIRD,
		LK_READ,
		LK_LOCKED
	} lock_st_t;

	// ways a random lock sequence gets broken
	typedef enum int {
		FLAW_NONE,
		FLAW_DATA,
		FLAW_KEY,
		FLAW_EARLY_READ,
		FLAW_LATE_WRITE
	} flaw_t;

	// one input beat plus an optional hand-typed answer
	typedef struct packed {
		opcode_t op;
		ofs_t    ofs;
		word_t   wd;
		pins_t   pins;
		logic    fixed;
		result_t want;
	} row_t;

	// dut signals; the inputs are known from time zero
	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 in_valid     = 1'b0;
	logic                 in_stall;
	logic [1:0]           opcode       = '0;
	ofs_t                 byte_offset  = '0;
	word_t                write_data   = '0;
	pins_t                pin_levels   = '0;
	logic                 out_valid;
	logic                 out_stall    = 1'b0;
	word_t                read_data;
	logic                 access_error;
	logic                 cfg_valid    = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index    = '0;
	word_t                cfg_data     = '0;

	// hand-typed answer travelling with the driven beat
	logic    fixed_on  = 1'b0;
	result_t fixed_val = '0;

	// no idling on either side while set
	logic calm = 1'b0;

	// shadow copy of the port registers
	word_t    shd_mode, shd_speed, shd_pull, shd_altl, shd_alth;
	pins_t    shd_otype, shd_odr;
	logic [LOCK_W-1:0] shd_lock_word;
	lock_st_t shd_lock_st;
	word_t    rst_mode, rst_speed, rst_pull;

	result_t pending_results [$];
	int      in_count    = 0;
	int      cfg_count   = 0;
	int      beats_sent  = 0;
	int      errors      = 0;
	int      quiet_cycles = 0;

	row_t dir_rows [N_DIR];

	gpio_port_registers_with_lock uut (
		.clk, .arst_n,
		.in_valid, .in_stall, .opcode, .byte_offset, .write_data, .pin_levels,
		.out_valid, .out_stall, .read_data, .access_error,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data
	);

	always #4 clk = ~clk;

	// ---------------------------------------------------------------
	// shadow model of the port
	// ---------------------------------------------------------------

	// port reset beat: everything back to its reset value, lock released
	function automatic void port_restore();
		shd_mode      = rst_mode;
		shd_speed     = rst_speed;
		shd_pull      = rst_pull;
		shd_otype     = '0;
		shd_odr       = '0;
		shd_lock_word = '0;
		shd_altl      = '0;
		shd_alth      = '0;
		shd_lock_st   = LK_FIRST;
	endfunction

	// one access to the lock register moves the key sequence along
	function automatic void lock_key_step(logic is_rd, word_t v);
		if (shd_lock_st == LK_LOCKED)
			return;
		// a key write whose pin mask differs from the stored one aborts
		if (!is_rd && (shd_lock_st == LK_SECOND || shd_lock_st == LK_THIRD) &&
		    shd_lock_word[PINS-1:0] != v[PINS-1:0]) begin
			shd_lock_st = LK_FIRST;
			return;
		end
		case (shd_lock_st)
			LK_FIRST: begin
				if (!is_rd && v[PINS]) begin
					shd_lock_word = v[LOCK_W-1:0];
					shd_lock_st   = LK_SECOND;
				end
			end
			LK_SECOND: begin
				if (!is_rd && !v[PINS]) begin
					shd_lock_word = v[LOCK_W-1:0];
					shd_lock_st   = LK_THIRD;
				end else
					shd_lock_st = LK_FIRST;
			end
			LK_THIRD: begin
				if (!is_rd && v[PINS]) begin
					shd_lock_word = v[LOCK_W-1:0];
					shd_lock_st   = LK_READ;
				end else
					shd_lock_st = LK_FIRST;
			end
			LK_READ:  shd_lock_st = is_rd ? LK_LOCKED : LK_FIRST;
			default:  shd_lock_st = LK_FIRST;
		endcase
	endfunction

	// applies one beat to the shadow registers and returns its result beat
	function automatic result_t gpio_access(opcode_t op, ofs_t ofs, word_t wd, pins_t pins);
		result_t r;
		logic    frozen;
		r = '0;
		frozen = (shd_lock_st == LK_LOCKED);
		case (op)
			OP_RESET: port_restore();
			OP_READ, OP_WRITE: begin
				if (ofs >= REGION)
					r.access_error = 1'b1;
				else if (op == OP_READ) begin
					case (ofs)
						OFS_MODE:  r.read_data = shd_mode;
						OFS_TYPE:  r.read_data = {16'h0, shd_otype};
						OFS_SPEED: r.read_data = shd_speed;
						OFS_PULL:  r.read_data = shd_pull;
						OFS_IDR:   r.read_data = {16'h0, pins};
						OFS_ODR:   r.read_data = {16'h0, shd_odr};
						OFS_BSRR:  r.access_error = 1'b1;
						OFS_LOCK: begin
							// the read that completes the sequence sees the locked word
							lock_key_step(1'b1, {15'h0, shd_lock_word});
							r.read_data = {15'h0, shd_lock_word};
						end
						OFS_ALTL:  r.read_data = shd_altl;
						OFS_ALTH:  r.read_data = shd_alth;
						default: ;
					endcase
				end else begin
					case (ofs)
						OFS_MODE:  if (!frozen) shd_mode = wd;
						OFS_TYPE:  if (!frozen) shd_otype = wd[PINS-1:0];
						OFS_SPEED: if (!frozen) shd_speed = wd;
						OFS_PULL:  if (!frozen) shd_pull = wd;
						OFS_IDR:   r.access_error = 1'b1;
						OFS_ODR:   shd_odr = wd[PINS-1:0];
						// set half wins over reset half on the same pin
						OFS_BSRR:  shd_odr = (shd_odr & ~wd[PINS-1:0]) | wd[DATA_W-1:PINS];
						OFS_LOCK:  lock_key_step(1'b0, wd);
						OFS_ALTL:  if (!frozen) shd_altl = wd;
						OFS_ALTH:  if (!frozen) shd_alth = wd;
						default: ;
					endcase
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// ---------------------------------------------------------------
	// checking
	// ---------------------------------------------------------------

	task automatic report_mismatch(string what, word_t got, word_t want);
		if (errors < MAX_REPORTS)
			$display("%0t ns: mismatch on %s: got %h, want %h", $time, what, got, want);
		errors++;
	endtask

	// sample everything at the rising edge; results are checked before the
	// input beat of the same edge is predicted
	always @(posedge clk) begin
		result_t got, want, pred;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got = {read_data, access_error};
				if (pending_results.size() == 0)
					report_mismatch("result beat with nothing pending", got.read_data, '0);
				else begin
					want = pending_results.pop_front();
					if (got.read_data !== want.read_data)
						report_mismatch("read_data", got.read_data, want.read_data);
					if (got.access_error !== want.access_error)
						report_mismatch("access_error", {31'h0, got.access_error},
						                {31'h0, want.access_error});
				end
			end
			if (in_valid && !in_stall) begin
				pred = gpio_access(opcode_t'(opcode), byte_offset, write_data, pin_levels);
				pending_results.push_back(fixed_on ? fixed_val : pred);
				in_count++;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_MODE_RST:  rst_mode  = cfg_data;
					CFG_SPEED_RST: rst_speed = cfg_data;
					CFG_PULL_RST:  rst_pull  = cfg_data;
					default: ;
				endcase
				cfg_count++;
			end
		end
	end

	// watchdog: too long with no beat moving on any channel
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
		    (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb_gpio_port_registers_with_lock: FAIL");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	// ---------------------------------------------------------------
	// stimulus
	// ---------------------------------------------------------------

	// consumer holds off about a third of the cycles unless calm
	always @(negedge clk)
		out_stall <= !calm && ($urandom_range(99) < 35);

	function automatic row_t beat(opcode_t op, ofs_t ofs, word_t wd, pins_t pins,
	                              logic fixed, word_t rd, logic err);
		row_t b;
		b.op    = op;
		b.ofs   = ofs;
		b.wd    = wd;
		b.pins  = pins;
		b.fixed = fixed;
		b.want  = {rd, err};
		return b;
	endfunction

	// drives one beat from a falling edge and returns at the falling edge
	// after it was taken; valid stays high unless an idle gap comes next
	task automatic send_beat(row_t b);
		int n;
		while (!calm && $urandom_range(99) < 35) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		n = in_count;
		in_valid    <= 1'b1;
		opcode      <= b.op;
		byte_offset <= b.ofs;
		write_data  <= b.wd;
		pin_levels  <= b.pins;
		fixed_on    <= b.fixed;
		fixed_val   <= b.want;
		beats_sent++;
		do @(negedge clk); while (in_count == n);
	endtask

	// lowers valid and waits until every result beat is back
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, word_t val);
		int n;
		n = cfg_count;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(negedge clk); while (cfg_count == n);
	endtask

	// back-to-back config beats, valid dropped only after the last one
	task automatic load_reset_values(word_t m, word_t s, word_t p);
		cfg_write(CFG_MODE_RST, m);
		cfg_write(CFG_SPEED_RST, s);
		cfg_write(CFG_PULL_RST, p);
		if ($urandom_range(1))
			cfg_write(CFG_SPARE, $urandom());
		cfg_valid <= 1'b0;
	endtask

	function automatic word_t rand_word();
		case ($urandom_range(7))
			0:       return '0;
			1:       return '1;
			default: return $urandom();
		endcase
	endfunction

	function automatic ofs_t pick_reg();
		case ($urandom_range(9))
			0:       return OFS_MODE;
			1:       return OFS_TYPE;
			2:       return OFS_SPEED;
			3:       return OFS_PULL;
			4:       return OFS_IDR;
			5:       return OFS_ODR;
			6:       return OFS_BSRR;
			7:       return OFS_LOCK;
			8:       return OFS_ALTL;
			default: return OFS_ALTH;
		endcase
	endfunction

	// mostly mapped register accesses, with port resets, unused opcodes
	// and random offsets (mostly out of range) mixed in
	task automatic random_access();
		row_t b;
		int   r;
		b      = '0;
		r      = $urandom_range(99);
		b.wd   = rand_word();
		b.pins = pins_t'($urandom_range(65535));
		b.ofs  = pick_reg();
		b.op   = $urandom_range(1) ? OP_WRITE : OP_READ;
		if (r < 5)
			b.op = OP_RESET;
		else if (r < 8) begin
			b.op  = OP_NONE;
			b.ofs = ofs_t'($urandom_range(4095));
		end else if (r < 18)
			b.ofs = ofs_t'($urandom_range(4095));
		send_beat(b);
	endtask

	// key 1, key 0, key 1 with one pin mask, then a read; some get broken
	task automatic lock_burst();
		row_t  b;
		flaw_t flaw;
		pins_t mask;
		mask = pins_t'($urandom_range(65535));
		flaw = ($urandom_range(99) < 70) ? FLAW_NONE : flaw_t'($urandom_range(4, 1));
		b      = '0;
		b.op   = OP_WRITE;
		b.ofs  = OFS_LOCK;
		b.pins = pins_t'($urandom_range(65535));
		// bits above the key are don't-care, keep them moving
		b.wd = {15'($urandom_range(32767)), 1'b1, mask};
		send_beat(b);
		b.wd = {15'($urandom_range(32767)), 1'b0, mask};
		if (flaw == FLAW_DATA)
			b.wd[PINS-1:0] = mask ^ pins_t'($urandom_range(65535, 1));
		if (flaw == FLAW_KEY)
			b.wd[PINS] = 1'b1;
		send_beat(b);
		b.wd = {15'($urandom_range(32767)), 1'b1, mask};
		if (flaw == FLAW_EARLY_READ)
			b.op = OP_READ;
		send_beat(b);
		b.op = (flaw == FLAW_LATE_WRITE) ? OP_WRITE : OP_READ;
		send_beat(b);
	endtask

	initial begin
		rst_mode  = '0;
		rst_speed = '0;
		rst_pull  = '0;
		port_restore();

		// directed table: hand-typed answers where obvious, shadow model elsewhere
		dir_rows = '{
			// mode register right after reset
			beat(OP_READ,  OFS_MODE,       32'h0,         16'h0000, 1'b1, 32'h0,         1'b0),
			// input data follows the pins
			beat(OP_READ,  OFS_IDR,        32'h0,         16'hFFFF, 1'b1, 32'h0000FFFF,  1'b0),
			// illegal accesses: read of bit set/reset, write of input data
			beat(OP_READ,  OFS_BSRR,       32'h0,         16'h0000, 1'b1, 32'h0,         1'b1),
			beat(OP_WRITE, OFS_IDR,        32'hFFFFFFFF,  16'h0000, 1'b1, 32'h0,         1'b1),
			// out of range at the top and right at the region end
			beat(OP_READ,  OFS_TOP,        32'h0,         16'h0000, 1'b1, 32'h0,         1'b1),
			beat(OP_WRITE, OFS_REGION_END, 32'hFFFFFFFF,  16'hFFFF, 1'b1, 32'h0,         1'b1),
			// last word of the region and an unaligned offset are unmapped
			beat(OP_READ,  OFS_LAST_WORD,  32'h0,         16'h0000, 1'b1, 32'h0,         1'b0),
			beat(OP_READ,  OFS_UNALIGNED,  32'h0,         16'h0000, 1'b1, 32'h0,         1'b0),
			// unused opcode answers zero
			beat(OP_NONE,  OFS_TOP,        32'hFFFFFFFF,  16'hFFFF, 1'b1, 32'h0,         1'b0),
			beat(OP_WRITE, OFS_MODE,       32'hFFFFFFFF,  16'h0000, 1'b1, 32'h0,         1'b0),
			beat(OP_READ,  OFS_MODE,       32'h0,         16'h0000, 1'b0, 32'h0,         1'b0),
			// output type drops its upper half
			beat(OP_WRITE, OFS_TYPE,       32'hFFFFFFFF,  16'h0000, 1'b1, 32'h0,         1'b0),
			beat(OP_READ,  OFS_TYPE,       32'h0,         16'h0000, 1'b0, 32'h0,         1'b0),
			// alternate high reads back
			beat(OP_WRITE, OFS_ALTH,       32'hA5C30FF0,  16'h0000, 1'b1, 32'h0,         1'b0),
			beat(OP_READ,  OFS_ALTH,       32'h0,         16'h0000, 1'b0, 32'h0,         1'b0),
			// set and reset on the same pins, set wins
			beat(OP_WRITE, OFS_ODR,        32'h000000F0,  16'h0000, 1'b1, 32'h0,         1'b0),
			beat(OP_WRITE, OFS_BSRR,       32'h00FF0F0F,  16'h0000, 1'b1, 32'h0,         1'b0),
			beat(OP_READ,  OFS_ODR,        32'h0,         16'h0000, 1'b0, 32'h0,         1'b0),
			// full lock sequence, then a control write that must be ignored
			beat(OP_WRITE, OFS_LOCK,       32'h00015A5A,  16'h0000, 1'b0, 32'h0,         1'b0),
			beat(OP_WRITE, OFS_LOCK,       32'h00005A5A,  16'h0000, 1'b0, 32'h0,         1'b0),
			beat(OP_WRITE, OFS_LOCK,       32'h00015A5A,  16'h0000, 1'b0, 32'h0,         1'b0),
			beat(OP_READ,  OFS_LOCK,       32'h0,         16'h0000, 1'b0, 32'h0,         1'b0),
			beat(OP_WRITE, OFS_MODE,       32'h0,         16'h0000, 1'b0, 32'h0,         1'b0),
			beat(OP_READ,  OFS_MODE,       32'h0,         16'h0000, 1'b0, 32'h0,         1'b0),
			// port reset releases the lock
			beat(OP_RESET, OFS_MODE,       32'hFFFFFFFF,  16'hFFFF, 1'b1, 32'h0,         1'b0)
		};

		// reset once, released on a falling edge
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < N_DIR; i++)
			send_beat(dir_rows[i]);

		// random phases, each under its own reset values; the third runs
		// with no idling on either side
		for (int p = 0; p < N_PHASES; p++) begin
			drain_results();
			case (p)
				0:       load_reset_values('0, '0, '0);
				1:       load_reset_values('1, '1, '1);
				4:       load_reset_values(32'hAAAAAAAA, 32'h55555555, 32'h0F0F0F0F);
				default: load_reset_values($urandom(), $urandom(), $urandom());
			endcase
			calm <= (p == 2);
			// new reset values only land with a port reset beat
			send_beat(beat(OP_RESET, pick_reg(), rand_word(), 16'h0000, 1'b0, 32'h0, 1'b0));
			while (beats_sent < N_DIR + (p + 1) * BEATS_PER_PHASE) begin
				if ($urandom_range(99) < 20)
					lock_burst();
				else
					random_access();
			end
		end
		calm <= 1'b0;

		drain_results();
		repeat (8) @(negedge clk);
		if (errors == 0)
			$display("tb_gpio_port_registers_with_lock: PASS");
		else
			$display("tb_gpio_port_registers_with_lock: FAIL");
		$finish;
	end

endmodule
